// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/vws_pkg.sv =====
`default_nettype none

package vws_pkg;

	localparam int unsigned PIX_PER_WORD = 16;
	localparam int unsigned CNT_W        = $clog2(PIX_PER_WORD);

	localparam logic [7:0]  SCROLL_BASE   = 8'o330;
	localparam logic [7:0]  SCROLL_GAIN   = 8'o050;
	localparam logic [7:0]  SCROLL_RESET  = 8'd216;
	localparam logic [23:0] RGB_WHITE     = 24'h0ffffff;
	localparam logic [23:0] RGB_BLACK     = 24'h000000;

	localparam logic OP_LOCATE = 1'b0;
	localparam logic OP_EXPAND = 1'b1;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SCROLL   = 3'd0;
	localparam logic [2:0] REG_FULL     = 3'd1;
	localparam logic [2:0] REG_COLOR    = 3'd2;
	localparam logic [2:0] REG_EXT_PAL  = 3'd3;
	localparam logic [2:0] REG_PAL_SEL  = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  row;
		logic [4:0]  word_column;
		logic [15:0] video_word;
	} in_item_t;

	typedef struct packed {
		logic [13:0] source_address;
		logic [8:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [23:0] rgb;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] scroll_offset;
		logic       full_screen;
		logic       color_mode;
		logic       extended_palettes;
		logic [3:0] palette_select;
	} cfg_t;

	function automatic logic [23:0] fixed_colour(input logic [1:0] idx);
		logic [23:0] c;
		case (idx)
			2'd0: c = 24'h000000;
			2'd1: c = 24'h0000FF;
			2'd2: c = 24'h00FF00;
			default: c = 24'hFF0000;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] chosen_colour(input logic [3:0] sel,
			input logic [1:0] idx);
		logic [23:0] c;
		case ({sel, idx})
			6'h01: c = 24'h0000FF; 6'h02: c = 24'h00FF00; 6'h03: c = 24'hFF0000;
			6'h05: c = 24'hFFFF00; 6'h06: c = 24'hFF00FF; 6'h07: c = 24'hFF0000;
			6'h09: c = 24'h00FFFF; 6'h0a: c = 24'h0000FF; 6'h0b: c = 24'hFF00FF;
			6'h0d: c = 24'h00FF00; 6'h0e: c = 24'h00FFFF; 6'h0f: c = 24'hFFFF00;
			6'h11: c = 24'hFF00FF; 6'h12: c = 24'h00FFFF; 6'h13: c = 24'hFFFFFF;
			6'h15: c = 24'hFFFFFF; 6'h16: c = 24'hFFFFFF; 6'h17: c = 24'hFFFFFF;
			6'h19: c = 24'h7F0000; 6'h1a: c = 24'h7F0000; 6'h1b: c = 24'hFF0000;
			6'h1d: c = 24'h00FF7F; 6'h1e: c = 24'h00FF7F; 6'h1f: c = 24'hFFFF00;
			6'h21: c = 24'hFF00FF; 6'h22: c = 24'h7F00FF; 6'h23: c = 24'h7F007F;
			6'h25: c = 24'h00FF7F; 6'h26: c = 24'h7F00FF; 6'h27: c = 24'h7F0000;
			6'h29: c = 24'h00FF7F; 6'h2a: c = 24'h7F007F; 6'h2b: c = 24'h7F0000;
			6'h2d: c = 24'h00FFFF; 6'h2e: c = 24'hFFFF00; 6'h2f: c = 24'hFF0000;
			6'h31: c = 24'hFF0000; 6'h32: c = 24'h00FF00; 6'h33: c = 24'h00FFFF;
			6'h35: c = 24'h00FFFF; 6'h36: c = 24'hFFFF00; 6'h37: c = 24'hFFFFFF;
			6'h39: c = 24'hFFFF00; 6'h3a: c = 24'h00FF00; 6'h3b: c = 24'hFFFFFF;
			6'h3d: c = 24'h00FFFF; 6'h3e: c = 24'h00FF00; 6'h3f: c = 24'hFFFFFF;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/video_word_scanout.sv =====
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+--------------------------------
// item in   | start high, busy low   | in_item (opcode, row, column, word)
// result    | done, one cycle each   | result (address, x, y, rgb, last)
// config    | psel/penable/pwrite    | paddr, pwdata, prdata
//
// locate gives one result; expand gives one pixel per cycle from the pixel counter
// a new item is taken at the edge that registers the final pixel of the previous one
// each result appears on the cycle after it is computed, registered output
// reset restores the register defaults and empties the pipeline
// the receiver cannot stall: every result transfer completes in its cycle

module video_word_scanout
	import vws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire in_item_t    in_item,
	output      logic        done,
	output      out_item_t   result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	cfg_t cfg;

	vws_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vws_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== rtl/vws_cfg.sv =====
`default_nettype none

module vws_cfg
	import vws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	output      cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scroll_offset     <= SCROLL_RESET;
			cfg_q.full_screen       <= 1'b1;
			cfg_q.color_mode        <= 1'b0;
			cfg_q.extended_palettes <= 1'b0;
			cfg_q.palette_select    <= 4'd0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SCROLL:  cfg_q.scroll_offset     <= pwdata[7:0];
				REG_FULL:    cfg_q.full_screen       <= pwdata[0];
				REG_COLOR:   cfg_q.color_mode        <= pwdata[0];
				REG_EXT_PAL: cfg_q.extended_palettes <= pwdata[0];
				REG_PAL_SEL: cfg_q.palette_select    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCROLL:  prdata = {24'd0, cfg_q.scroll_offset};
			REG_FULL:    prdata = {31'd0, cfg_q.full_screen};
			REG_COLOR:   prdata = {31'd0, cfg_q.color_mode};
			REG_EXT_PAL: prdata = {31'd0, cfg_q.extended_palettes};
			REG_PAL_SEL: prdata = {28'd0, cfg_q.palette_select};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/vws_engine.sv =====
`default_nettype none
`include "assert_macros.svh"

module vws_engine
	import vws_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      start,
	output      logic      busy,
	input  wire in_item_t  in_item,
	output      logic      done,
	output      out_item_t result
);

	logic             valid_s1;
	in_item_t         item_s1;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	out_item_t        result_q;

	logic             accept;
	logic             last_c;
	logic [7:0]       scroll_c;
	logic [7:0]       line_c;
	logic             blank_c;
	logic [1:0]       pair_c;
	logic [23:0]      colour_c;
	logic [23:0]      rgb_c;
	out_item_t        res_c;

	// the stage frees up on the cycle that computes a locate result or the final pixel of a run
	assign last_c = (item_s1.opcode == OP_LOCATE) || (cnt_q == CNT_W'(PIX_PER_WORD - 1));
	assign busy   = valid_s1 & ~last_c;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			valid_s1 <= accept;
			cnt_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// scroll remap: values at or above the base wrap down, others move up
	assign scroll_c = (cfg.scroll_offset >= SCROLL_BASE) ? cfg.scroll_offset - SCROLL_BASE
							      : cfg.scroll_offset + SCROLL_GAIN;
	assign line_c   = item_s1.row + scroll_c;
	assign blank_c  = ~cfg.full_screen & (item_s1.row[7:6] != 2'd0);
	assign pair_c   = item_s1.video_word[{cnt_q[CNT_W-1:1], 1'b0} +: 2];

	always_comb begin
		if (cfg.extended_palettes) begin
			colour_c = chosen_colour(cfg.palette_select, pair_c);
		end else begin
			colour_c = fixed_colour(pair_c);
		end
		if (blank_c) begin
			rgb_c = RGB_BLACK;
		end else if (cfg.color_mode) begin
			rgb_c = colour_c;
		end else begin
			rgb_c = item_s1.video_word[cnt_q] ? RGB_WHITE : RGB_BLACK;
		end
	end

	always_comb begin
		res_c.source_address = {line_c, item_s1.word_column, 1'b0};
		res_c.last           = last_c;
		if (item_s1.opcode == OP_LOCATE) begin
			res_c.pixel_x = '0;
			res_c.pixel_y = '0;
			res_c.rgb     = '0;
		end else begin
			res_c.pixel_x = {item_s1.word_column, cnt_q};
			res_c.pixel_y = ~item_s1.row;
			res_c.rgb     = rgb_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_c;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_IMPLY(a_done_has_item, clk, arst_n, done, $past(valid_s1))
	`ASSERT_NEXT(a_accept_loads, clk, arst_n, accept, valid_s1 && (cnt_q == '0))
	`ASSERT_NEXT(a_run_advances, clk, arst_n, busy,
		valid_s1 && (cnt_q == $past(cnt_q) + 1'b1) && $stable(item_s1))
	`ASSERT_IMPLY(a_last_frees, clk, arst_n, done && result.last, !$past(busy))

endmodule

`default_nettype wire
